// ===== src/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg: shared codes and types for the generational handle pool
// Operation and status codes, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package ghp_pkg;

    // operation codes; code 3 is unused and answers as an invalid handle
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_VALIDATE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // field widths of the result and request
    localparam int unsigned HANDLE_W  = 16;
    localparam int unsigned OUT_IDX_W = 8;
    localparam int unsigned OUT_GEN_W = 16;

    // controller to datapath commands
    typedef struct packed {
        logic latch;         // capture the request
        logic pop;           // read free stack top, drop the count
        logic take_fresh;    // take the slot at the high-water mark
        logic take_pop;      // take the popped slot, read its table entry
        logic read_handle;   // read the table entry of the handle
        logic commit_alloc;  // write the new generation, emit the handle
        logic commit_check;  // finish release or validate, emit the answer
        logic emit_full;     // emit pool full
        logic emit_invalid;  // emit invalid for an unused operation
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       stack_nonempty;
        logic       hw_room;
    } t_dp_stat;

endpackage

// ===== src/ghp_datapath.sv =====
// ----------------------------------------------------------------------------
// ghp_datapath: slot table, free stack, counters and result registers
// Executes controller commands; memories have registered read data.
// ----------------------------------------------------------------------------
module ghp_datapath
    import ghp_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_dp_stat              o_stat,
    input  logic [1:0]            i_operation,
    input  logic [HANDLE_W-1:0]   i_handle_index,
    input  logic [HANDLE_W-1:0]   i_handle_generation,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [OUT_IDX_W-1:0]  o_slot_index,
    output logic [OUT_GEN_W-1:0]  o_generation
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;
    localparam int GW = (GEN_BITS > OUT_GEN_W) ? GEN_BITS : OUT_GEN_W;
    localparam int LW = (CW > HANDLE_W) ? CW : HANDLE_W;

    // slot table entry: {alive, generation}
    logic [GEN_BITS:0] r_table [SLOTS];
    logic [GEN_BITS:0] r_table_q;
    logic [IW-1:0]     r_stack [SLOTS];
    logic [IW-1:0]     r_stack_q;

    logic [CW-1:0]       r_count, r_hw;
    logic [1:0]          r_op;
    logic [HANDLE_W-1:0] r_hidx, r_hgen;
    logic [IW-1:0]       r_slot;
    logic                r_fresh;

    logic                 r_valid;
    logic [1:0]           r_status;
    logic [OUT_IDX_W-1:0] r_slot_out;
    logic [OUT_GEN_W-1:0] r_gen_out;

    logic [GEN_BITS-1:0] stored_gen, alloc_base, gen_inc, gen_new;
    logic                alive, handle_ok, is_release, do_free, count_room;
    logic [CW-1:0]       cnt_dec;
    logic [IW-1:0]       hidx_addr;
    logic [XW-1:0]       slot_wide;
    logic [GW-1:0]       gen_new_wide, stored_wide, hgen_wide;

    logic                 tbl_we, tbl_re, stk_we;
    logic [IW-1:0]        tbl_waddr, tbl_raddr;
    logic [GEN_BITS:0]    tbl_wdata;

    logic                 n_valid;
    logic [1:0]           n_status;
    logic [OUT_IDX_W-1:0] n_slot_out;
    logic [OUT_GEN_W-1:0] n_gen_out;

    always_comb begin
        stored_gen = r_table_q[GEN_BITS-1:0];
        alive      = r_table_q[GEN_BITS];
        alloc_base = r_fresh ? '0 : stored_gen;
        gen_inc    = alloc_base + GEN_BITS'(1);
        gen_new    = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
        hidx_addr  = r_hidx[IW-1:0];
        cnt_dec    = r_count - CW'(1);
        count_room = r_count < CW'(SLOTS);
        is_release = r_op == OP_RELEASE;
        hgen_wide    = GW'(r_hgen);
        stored_wide  = GW'(stored_gen);
        gen_new_wide = GW'(gen_new);
        slot_wide    = XW'(r_slot);
        handle_ok  = (r_hgen != '0) && (LW'(r_hidx) < LW'(r_hw)) && alive
                     && (stored_wide == hgen_wide);
        do_free    = i_cmd.commit_check && handle_ok && is_release;
    end

    // memory ports
    always_comb begin
        tbl_we    = i_cmd.commit_alloc || do_free;
        tbl_waddr = i_cmd.commit_alloc ? r_slot : hidx_addr;
        tbl_wdata = i_cmd.commit_alloc ? {1'b1, gen_new} : {1'b0, stored_gen};
        tbl_re    = i_cmd.take_pop || i_cmd.read_handle;
        tbl_raddr = i_cmd.take_pop ? r_stack_q : hidx_addr;
        stk_we    = do_free && count_room;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_table_q <= r_table[tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_count[IW-1:0]] <= hidx_addr;
        end
        if (i_cmd.pop) begin
            r_stack_q <= r_stack[cnt_dec[IW-1:0]];
        end
    end

    // result selection
    always_comb begin
        n_valid    = i_cmd.commit_alloc || i_cmd.commit_check
                     || i_cmd.emit_full || i_cmd.emit_invalid;
        n_status   = ST_INVALID;
        n_slot_out = r_hidx[OUT_IDX_W-1:0];
        n_gen_out  = '0;
        if (i_cmd.commit_alloc) begin
            n_status   = ST_OK;
            n_slot_out = slot_wide[OUT_IDX_W-1:0];
            n_gen_out  = gen_new_wide[OUT_GEN_W-1:0];
        end else if (i_cmd.commit_check) begin
            if (handle_ok) begin
                n_status  = ST_OK;
                n_gen_out = stored_wide[OUT_GEN_W-1:0];
            end
        end else if (i_cmd.emit_full) begin
            n_status   = ST_FULL;
            n_slot_out = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hw    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.pop) begin
                r_count <= cnt_dec;
            end else if (stk_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.take_fresh) begin
                r_hw <= r_hw + CW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_hidx <= i_handle_index;
            r_hgen <= i_handle_generation;
        end
        if (i_cmd.take_fresh) begin
            r_slot  <= r_hw[IW-1:0];
            r_fresh <= 1'b1;
        end else if (i_cmd.take_pop) begin
            r_slot  <= r_stack_q;
            r_fresh <= 1'b0;
        end
        if (n_valid) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_gen_out  <= n_gen_out;
        end
    end

    assign o_stat.op             = r_op;
    assign o_stat.stack_nonempty = r_count != '0;
    assign o_stat.hw_room        = r_hw < CW'(SLOTS);

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot_out;
    assign o_generation = r_gen_out;

endmodule

// ===== src/ghp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ghp_ctrl: operation sequencer for the generational handle pool
// Steps each request through read, decide and commit cycles.
// ----------------------------------------------------------------------------
module ghp_ctrl
    import ghp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_POPW,
        S_ALLOC,
        S_CHECK
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (i_stat.op == OP_ALLOC) begin
                    if (i_stat.stack_nonempty) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_POPW;
                    end else if (i_stat.hw_room) begin
                        o_cmd.take_fresh = 1'b1;
                        n_state          = S_ALLOC;
                    end else begin
                        o_cmd.emit_full = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.op == OP_RELEASE || i_stat.op == OP_VALIDATE) begin
                    o_cmd.read_handle = 1'b1;
                    n_state           = S_CHECK;
                end else begin
                    o_cmd.emit_invalid = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_POPW: begin
                o_cmd.take_pop = 1'b1;
                n_state        = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.commit_alloc = 1'b1;
                n_state            = S_IDLE;
            end
            S_CHECK: begin
                o_cmd.commit_check = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = n_state != S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

// ===== src/generational_handle_pool_top.sv =====
// Steps to the result strobe: pool full and unused operations are answered from the issue state;
// release, validate and allocate of a never-used slot pass on to the check or commit state;
// allocate from the free stack reads the stack, then the table, through registered memories.
// Requests: one in flight at a time; busy drops as the result is strobed, so the
// next request is accepted in the strobe cycle. The receiver cannot stall.
// Reset (synchronous, active low) empties the pool: stack count and high-water mark to 0.
// ----------------------------------------------------------------------------
// generational_handle_pool_top: slot pool handing out generation-tagged handles
// Allocate, release and validate of (index, generation) handles over SLOTS slots.
// ----------------------------------------------------------------------------
module generational_handle_pool_top
    import ghp_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [HANDLE_W-1:0]  i_handle_index,
    input  logic [HANDLE_W-1:0]  i_handle_generation,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [OUT_IDX_W-1:0] o_slot_index,
    output logic [OUT_GEN_W-1:0] o_generation
);

    // Controller and datapath talk only through these two bundles.
    t_cmd     cmd;
    t_dp_stat dp_stat;

    // Sequencer: one request in flight; it owns busy.
    ghp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (cmd)
    );

    // Datapath: slot table {alive, generation} and free stack as memories.
    // Slots at or above the high-water mark are never read as live, and a
    // slot taken at the mark starts from generation zero, so the table
    // needs no clearing pass after reset.
    ghp_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (dp_stat),
        .i_operation         (i_operation),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_slot_index        (o_slot_index),
        .o_generation        (o_generation)
    );

    // A result is strobed only as the block goes idle.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // Pool full carries a null handle.
    a_full_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_generation == '0 && o_slot_index == '0))
        else $error("pool full with non-null handle");

    // A successful answer never carries generation zero.
    a_ok_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_generation != '0 || GEN_BITS > OUT_GEN_W))
        else $error("ok result with generation zero");

endmodule

// ===== test/tb_generational_handle_pool_top.sv =====
// ----------------------------------------------------------------------------
// tb_generational_handle_pool_top: self-checking bench for the handle pool
// Drives allocate, release and validate transfers through the start/busy
// handshake, predicts every answer with a bit-true pool model kept in the
// bench, and checks each strobed result field by field, in order.
// ----------------------------------------------------------------------------
module tb_generational_handle_pool_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ghp_pkg::*;

    localparam int          POOL_SLOTS    = 256;
    localparam int          POOL_GEN_BITS = 16;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;   // no package name for code 3
    localparam int          RANDOM_ITEMS  = 870;
    localparam int          DRAIN_CYCLES  = 8;      // idle watch for a stray strobe at the end
    localparam int unsigned RUN_LIMIT     = 3_000_000;
    localparam int          PRINT_CAP     = 20;

    typedef struct packed {
        logic [1:0]          op;
        logic [HANDLE_W-1:0] idx;
        logic [HANDLE_W-1:0] gen;
    } pool_request_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] slot;
        logic [OUT_GEN_W-1:0] gen;
    } pool_result_t;

    // typed rows carry a hand-written answer; the others take the prediction
    typedef struct packed {
        pool_request_t req;
        logic          typed;
        pool_result_t  answer;
    } directed_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_operation;
    logic [HANDLE_W-1:0]  i_handle_index;
    logic [HANDLE_W-1:0]  i_handle_generation;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [OUT_IDX_W-1:0] o_slot_index;
    logic [OUT_GEN_W-1:0] o_generation;

    // bench copy of the pool
    logic                     pool_alive [POOL_SLOTS];
    logic [POOL_GEN_BITS-1:0] pool_gen   [POOL_SLOTS];
    logic [7:0]               pool_stack [POOL_SLOTS];
    int unsigned              pool_free_count;
    int unsigned              pool_high_water;

    pool_result_t  awaited_answers [$];
    directed_row_t directed_rows [$];

    int unsigned cycle_count;
    int unsigned transfers_sent;
    int unsigned answers_checked;
    int unsigned error_count;
    int unsigned full_answers;
    int unsigned wrap_count;

    generational_handle_pool_top #(
        .SLOTS    (POOL_SLOTS),
        .GEN_BITS (POOL_GEN_BITS)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_slot_index        (o_slot_index),
        .o_generation        (o_generation)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pool predictor
    // ------------------------------------------------------------------
    task automatic pool_clear();
        for (int s = 0; s < POOL_SLOTS; s++) begin
            pool_alive[s] = 1'b0;
            pool_gen[s]   = '0;
            pool_stack[s] = '0;
        end
        pool_free_count = 0;
        pool_high_water = 0;
    endtask

    // a handle is current when non-null, below the high-water mark, alive
    // and carrying the stored generation
    function automatic logic handle_current(input logic [HANDLE_W-1:0] idx,
                                            input logic [HANDLE_W-1:0] gen);
        if (gen == '0 || 32'(idx) >= pool_high_water || 32'(idx) >= POOL_SLOTS)
            return 1'b0;
        return pool_alive[idx[7:0]] && (pool_gen[idx[7:0]] == gen);
    endfunction

    task automatic pool_apply(input pool_request_t req, output pool_result_t res);
        logic [7:0]               slot;
        logic [POOL_GEN_BITS-1:0] next_gen;
        logic                     taken;
        // default answer: invalid handle, echo of the low index bits
        res.status = ST_INVALID;
        res.slot   = req.idx[OUT_IDX_W-1:0];
        res.gen    = '0;
        taken      = 1'b1;
        slot       = '0;
        case (req.op)
            OP_ALLOC: begin
                if (pool_free_count > 0) begin
                    pool_free_count--;
                    slot = pool_stack[pool_free_count];
                end else if (pool_high_water < POOL_SLOTS) begin
                    slot = 8'(pool_high_water);
                    pool_high_water++;
                end else begin
                    taken = 1'b0;
                end
                if (taken) begin
                    // advance the generation, skip the null value on wrap
                    next_gen = pool_gen[slot] + POOL_GEN_BITS'(1);
                    if (next_gen == '0) begin
                        next_gen = POOL_GEN_BITS'(1);
                        wrap_count++;
                    end
                    pool_gen[slot]   = next_gen;
                    pool_alive[slot] = 1'b1;
                    res.status       = ST_OK;
                    res.slot         = slot;
                    res.gen          = next_gen;
                end else begin
                    res.status = ST_FULL;
                    res.slot   = '0;
                    full_answers++;
                end
            end
            OP_RELEASE: begin
                if (handle_current(req.idx, req.gen)) begin
                    pool_alive[req.idx[7:0]] = 1'b0;
                    if (pool_free_count < POOL_SLOTS) begin
                        pool_stack[pool_free_count] = req.idx[7:0];
                        pool_free_count++;
                    end
                    res.status = ST_OK;
                    res.gen    = pool_gen[req.idx[7:0]];
                end
            end
            OP_VALIDATE: begin
                if (handle_current(req.idx, req.gen)) begin
                    res.status = ST_OK;
                    res.gen    = pool_gen[req.idx[7:0]];
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Hold the request until the edge where busy is low, then predict it.
    // The answer is strobed only after the issue state that follows the accepting
    // edge, so the expectation is queued well before the monitor needs it.
    task automatic send_request(input pool_request_t req, input logic typed,
                                input pool_result_t answer, output pool_result_t predicted);
        start               <= 1'b1;
        i_operation         <= req.op;
        i_handle_index      <= req.idx;
        i_handle_generation <= req.gen;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pool_apply(req, predicted);
        awaited_answers = {awaited_answers, (typed ? answer : predicted)};
        transfers_sent++;
    endtask

    // drop start while idling; with n == 0 the request stays up back to back
    task automatic idle_for(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drop start and hold off until every answer is back; always pass a clock
    // edge first, so start is never lowered and raised in the same step
    task automatic drain_answers();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (awaited_answers.size() != 0);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [15:0] idx,
                           input logic [15:0] gen, input logic typed,
                           input logic [1:0] status, input logic [7:0] slot,
                           input logic [15:0] out_gen);
        directed_row_t row;
        row.req.op        = op;
        row.req.idx       = idx;
        row.req.gen       = gen;
        row.typed         = typed;
        row.answer.status = status;
        row.answer.slot   = slot;
        row.answer.gen    = out_gen;
        directed_rows = {directed_rows, row};
    endtask

    // Mostly well-formed handles taken from the live table, some stale,
    // some pure noise including the unused operation and wide indexes.
    task automatic random_request(input int alloc_pct, output pool_request_t req);
        int unsigned pick;
        int unsigned s;
        pick    = $urandom_range(0, 99);
        req.op  = OP_ALLOC;
        req.idx = HANDLE_W'($urandom);
        req.gen = HANDLE_W'($urandom);
        if (pick < 32'(alloc_pct)) begin
            req.op = OP_ALLOC;
        end else if (pick < 88 && pool_high_water > 0) begin
            s       = $urandom_range(0, pool_high_water - 1);
            req.op  = ($urandom_range(0, 2) == 0) ? OP_VALIDATE : OP_RELEASE;
            req.idx = HANDLE_W'(s);
            req.gen = pool_gen[s];
            // flip one generation bit now and then to make it stale
            if ($urandom_range(0, 7) == 0)
                req.gen = req.gen ^ (HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1));
        end else begin
            req.op = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                req.gen = '0;
            if ($urandom_range(0, 1) == 0)
                req.idx = HANDLE_W'($urandom_range(0, POOL_SLOTS + 3));
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("MISMATCH %s: expected %0h got %0h (cycle %0d)",
                     what, want, got, cycle_count);
    endtask

    always @(posedge i_clk) begin : answer_check
        pool_result_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch("answer with nothing awaited", 32'd0,
                                32'({o_status, o_slot_index, o_generation}));
            end else begin
                want = awaited_answers.pop_front();
                answers_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_slot_index !== want.slot)
                    report_mismatch("slot_index", 32'(want.slot), 32'(o_slot_index));
                if (o_generation !== want.gen)
                    report_mismatch("generation", 32'(want.gen), 32'(o_generation));
            end
        end
    end

    // Watchdog: a hung handshake or a lost answer ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("generational_handle_pool_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        pool_request_t req;
        pool_result_t  scratch;
        pool_result_t  no_answer;
        int            alloc_pct;
        logic          calm;

        transfers_sent  = 0;
        answers_checked = 0;
        error_count     = 0;
        full_answers    = 0;
        wrap_count      = 0;
        no_answer       = '0;
        pool_clear();

        start               <= 1'b0;
        i_operation         <= OP_ALLOC;
        i_handle_index      <= '0;
        i_handle_generation <= '0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Right after reset the pool is empty, so each typed
        // answer follows by hand from allocation order; untyped rows predict.
        add_row(OP_VALIDATE, 16'h0000, 16'h0000, 1'b1, ST_INVALID, 8'h00, 16'h0000);
        add_row(OP_RELEASE,  16'h0005, 16'h0001, 1'b1, ST_INVALID, 8'h05, 16'h0000);
        add_row(OP_VALIDATE, 16'hFFFF, 16'hFFFF, 1'b1, ST_INVALID, 8'hFF, 16'h0000);
        add_row(OP_UNUSED,   16'h1234, 16'h0001, 1'b1, ST_INVALID, 8'h34, 16'h0000);
        add_row(OP_ALLOC,    16'hFFFF, 16'hFFFF, 1'b1, ST_OK,      8'h00, 16'h0001);
        add_row(OP_ALLOC,    16'h0000, 16'h0000, 1'b1, ST_OK,      8'h01, 16'h0001);
        add_row(OP_VALIDATE, 16'h0000, 16'h0001, 1'b1, ST_OK,      8'h00, 16'h0001);
        add_row(OP_VALIDATE, 16'h0000, 16'h0002, 1'b1, ST_INVALID, 8'h00, 16'h0000);
        // index at the high-water mark is never valid
        add_row(OP_VALIDATE, 16'h0002, 16'h0001, 1'b1, ST_INVALID, 8'h02, 16'h0000);
        add_row(OP_RELEASE,  16'h0000, 16'h0001, 1'b1, ST_OK,      8'h00, 16'h0001);
        // stale handle: second release and validate after free
        add_row(OP_RELEASE,  16'h0000, 16'h0001, 1'b1, ST_INVALID, 8'h00, 16'h0000);
        add_row(OP_VALIDATE, 16'h0000, 16'h0001, 1'b1, ST_INVALID, 8'h00, 16'h0000);
        add_row(OP_ALLOC,    16'h00AA, 16'h5555, 1'b1, ST_OK,      8'h00, 16'h0002);
        add_row(OP_ALLOC,    16'h5555, 16'hAAAA, 1'b1, ST_OK,      8'h02, 16'h0001);
        add_row(OP_RELEASE,  16'h0001, 16'h0001, 1'b1, ST_OK,      8'h01, 16'h0001);
        add_row(OP_RELEASE,  16'h0002, 16'h0001, 1'b1, ST_OK,      8'h02, 16'h0001);
        // free stack is LIFO: slot 2 comes back before slot 1
        add_row(OP_ALLOC,    16'h0000, 16'h0000, 1'b1, ST_OK,      8'h02, 16'h0002);
        add_row(OP_ALLOC,    16'h0000, 16'h0000, 1'b1, ST_OK,      8'h01, 16'h0002);
        // wide index: only the low byte is echoed
        add_row(OP_VALIDATE, 16'h0101, 16'h0002, 1'b1, ST_INVALID, 8'h01, 16'h0000);
        add_row(OP_RELEASE,  16'hFFFF, 16'h0000, 1'b1, ST_INVALID, 8'hFF, 16'h0000);
        add_row(OP_UNUSED,   16'hFFFF, 16'hFFFF, 1'b1, ST_INVALID, 8'hFF, 16'h0000);
        add_row(OP_VALIDATE, 16'h0001, 16'h0002, 1'b1, ST_OK,      8'h01, 16'h0002);
        add_row(OP_RELEASE,  16'h0000, 16'h0000, 1'b1, ST_INVALID, 8'h00, 16'h0000);
        add_row(OP_VALIDATE, 16'h0001, 16'h0000, 1'b0, ST_OK,      8'h00, 16'h0000);
        add_row(OP_RELEASE,  16'h0002, 16'h0002, 1'b0, ST_OK,      8'h00, 16'h0000);

        foreach (directed_rows[r]) begin
            idle_for($urandom_range(0, 15));
            send_request(directed_rows[r].req, directed_rows[r].typed,
                         directed_rows[r].answer, scratch);
        end
        drain_answers();

        // Fill the pool, then ask for two more slots: both must answer full.
        while (pool_free_count > 0 || pool_high_water < POOL_SLOTS) begin
            idle_for($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
            req.op  = OP_ALLOC;
            req.idx = HANDLE_W'($urandom);
            req.gen = HANDLE_W'($urandom);
            send_request(req, 1'b0, no_answer, scratch);
        end
        scratch.status = ST_FULL;
        scratch.slot   = '0;
        scratch.gen    = '0;
        req.op  = OP_ALLOC;
        req.idx = 16'hFFFF;
        req.gen = 16'hFFFF;
        send_request(req, 1'b1, scratch, scratch);
        scratch.status = ST_FULL;
        scratch.slot   = '0;
        scratch.gen    = '0;
        idle_for(7);
        send_request(req, 1'b1, scratch, scratch);
        drain_answers();

        // Random traffic in bursts of 64; each burst picks how hard it
        // allocates and whether the sender idles between transfers.
        alloc_pct = 20;
        calm      = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 15;
                    1:       alloc_pct = 45;
                    default: alloc_pct = 70;
                endcase
                calm = ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
                drain_answers();
            idle_for(calm ? 0 : int'($urandom_range(0, 15)));
            random_request(alloc_pct, req);
            send_request(req, 1'b0, no_answer, scratch);
        end

        // Hold off until the last answer is in, then keep watching while idle
        // for a stray strobe before deciding.
        drain_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transfers issued, %0d answers checked, %0d mismatches",
                 transfers_sent, answers_checked, error_count);
        $display("pool full answered %0d times, generation wrapped %0d times",
                 full_answers, wrap_count);
        if (error_count == 0) begin
            $display("generational_handle_pool_top verification clean");
        end else begin
            $display("generational_handle_pool_top verification failed");
        end
        $finish;
    end

endmodule
